// File: rtl/core/xcht_pkg.sv
// Shared types, constants and register codes for the XOR cipher with hash tag.
// No dependencies; the modules of the block import this package.
`default_nettype none

package xcht_pkg;

  localparam int KEY_BYTES = 32;
  localparam int KEY_BITS  = KEY_BYTES * 8;
  localparam int KEY_POS_W = $clog2(KEY_BYTES);
  localparam int KEY_LEN_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int HASH_W    = 32;

  localparam logic [HASH_W-1:0] HASH_START = 32'd5381;
  localparam logic [HASH_W-1:0] TAG_MASK   = 32'h7fff_ffff;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd5;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_SHORT    = 2'd2
  } status_t;

  typedef struct packed {
    logic                 mode;
    logic [KEY_LEN_W-1:0] key_length;
    logic [KEY_BITS-1:0]  key;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       end_of_message;
    status_t    status;
  } result_t;

endpackage : xcht_pkg

`default_nettype wire

// File: rtl/core/xcht_in_if.sv
// Input byte channel: valid/ready handshake with one message byte and end marker.
// No dependencies.
`default_nettype none

interface xcht_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       final_byte;

  modport source (output valid, output byte_value, output final_byte, input ready);
  modport sink   (input valid, input byte_value, input final_byte, output ready);
endinterface : xcht_in_if

`default_nettype wire

// File: rtl/core/xcht_out_if.sv
// Result channel: valid/ready handshake carrying one produced byte and end status.
// No dependencies.
`default_nettype none

interface xcht_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       end_of_message;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_present,
                  output end_of_message, output status, input ready);
  modport sink   (input valid, input out_byte, input byte_present,
                  input end_of_message, input status, output ready);
endinterface : xcht_out_if

`default_nettype wire

// File: rtl/core/xcht_cfg_if.sv
// Configuration write channel: valid/ready with register index and write data.
// No dependencies.
`default_nettype none

interface xcht_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : xcht_cfg_if

`default_nettype wire

// File: rtl/core/xcht_cfg_regs.sv
// Configuration register file: mode, key length and the 32 key bytes.
// Depends on xcht_pkg and xcht_cfg_if.
`default_nettype none

module xcht_cfg_regs (
  input  wire logic     clk,
  input  wire logic     rst_n,
  xcht_cfg_if.sink      cfg_ch,
  output xcht_pkg::cfg_t cfg
);
  import xcht_pkg::*;

  logic                 mode_r;
  logic [KEY_LEN_W-1:0] key_length_r;
  logic [KEY_BITS-1:0]  key_r;
  logic                 wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_ENCRYPT;
      key_length_r <= KEY_LEN_W'(1);
      key_r        <= '0;
    end else if (wr_en) begin
      case (cfg_ch.index)
        REG_MODE:       mode_r              <= cfg_ch.data[0];
        REG_KEY_LENGTH: key_length_r        <= cfg_ch.data[KEY_LEN_W-1:0];
        REG_KEY_WORD_0: key_r[63:0]         <= cfg_ch.data;
        REG_KEY_WORD_1: key_r[127:64]       <= cfg_ch.data;
        REG_KEY_WORD_2: key_r[191:128]      <= cfg_ch.data;
        REG_KEY_WORD_3: key_r[255:192]      <= cfg_ch.data;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  assign cfg.mode       = mode_r;
  assign cfg.key_length = key_length_r;
  assign cfg.key        = key_r;

endmodule : xcht_cfg_regs

`default_nettype wire

// File: rtl/core/xcht_out_fifo.sv
// Two-entry result buffer between the cipher core and the output channel.
// Depends on xcht_pkg and xcht_out_if.
`default_nettype none

module xcht_out_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  xcht_pkg::result_t   push_data,
  output logic                has_space,
  xcht_out_if.source          out_ch
);
  import xcht_pkg::*;

  result_t    mem [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       pop;
  result_t    head;

  assign has_space    = (count_r != 2'd2);
  assign out_ch.valid = (count_r != 2'd0);
  assign pop          = out_ch.valid && out_ch.ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + 2'd1;
    else if (!push && pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  assign head                  = mem[rd_ptr_r];
  assign out_ch.out_byte       = head.out_byte;
  assign out_ch.byte_present   = head.byte_present;
  assign out_ch.end_of_message = head.end_of_message;
  assign out_ch.status         = head.status;

endmodule : xcht_out_fifo

`default_nettype wire

// File: rtl/core/xcht_core.sv
// Cipher core: input register, key sequencing, DJB2 hash, tag append and check.
// Depends on xcht_pkg and xcht_in_if.
`default_nettype none

module xcht_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  xcht_in_if.sink            in_ch,
  input  xcht_pkg::cfg_t     cfg,
  input  wire logic          has_space,
  output logic               push,
  output xcht_pkg::result_t  push_data
);
  import xcht_pkg::*;

  // input register
  logic                 in_valid_r;
  logic [7:0]           in_byte_r;
  logic                 in_fin_r;

  // message state
  logic [HASH_W-1:0]    hash_r, hash_nxt;
  logic [KEY_POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]           held_r [4];
  logic [7:0]           held_nxt [4];
  logic [2:0]           held_cnt_r, held_cnt_nxt;

  // tag emission
  logic [2:0]           tag_cnt_r, tag_cnt_nxt;
  logic [HASH_W-1:0]    tag_r, tag_nxt;

  logic                 tag_busy, item_go, tag_go;
  logic [KEY_LEN_W-1:0] eff_len;
  logic [KEY_POS_W-1:0] key_pos;
  logic [7:0]           key_byte;
  logic [7:0]           plain;
  logic                 released;
  logic [7:0]           hash_byte;
  logic [HASH_W-1:0]    hash_sum;
  logic [HASH_W-1:0]    check_tag;
  status_t              dec_status;

  assign tag_busy    = (tag_cnt_r != 3'd0);
  assign item_go     = in_valid_r && !tag_busy && has_space;
  assign tag_go      = tag_busy && has_space;
  assign in_ch.ready = !in_valid_r || item_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.byte_value;
      in_fin_r  <= in_ch.final_byte;
    end
  end

  // effective key length clamped to 1..KEY_BYTES, position wrapped before use
  always_comb begin
    if (cfg.key_length == '0)
      eff_len = KEY_LEN_W'(1);
    else if (cfg.key_length > KEY_LEN_W'(KEY_BYTES))
      eff_len = KEY_LEN_W'(KEY_BYTES);
    else
      eff_len = cfg.key_length;
  end

  assign key_pos  = ({1'b0, pos_r} >= eff_len) ? '0 : pos_r;
  assign key_byte = cfg.key[{key_pos, 3'b000} +: 8];
  assign plain    = in_byte_r ^ key_byte;

  // decrypt releases the oldest held byte once four are held
  assign released  = (cfg.mode == MODE_DECRYPT) && (held_cnt_r == 3'd4);
  assign hash_byte = (cfg.mode == MODE_DECRYPT) ? held_r[0] : in_byte_r;
  assign hash_sum  = hash_r + {hash_r[HASH_W-6:0], 5'b00000} + {24'd0, hash_byte};

  always_comb begin
    for (int i = 0; i < 4; i++) held_nxt[i] = held_r[i];
    held_cnt_nxt = held_cnt_r;
    if (held_cnt_r == 3'd4) begin
      held_nxt[0] = held_r[1];
      held_nxt[1] = held_r[2];
      held_nxt[2] = held_r[3];
      held_nxt[3] = plain;
    end else begin
      held_nxt[held_cnt_r[1:0]] = plain;
      held_cnt_nxt = held_cnt_r + 3'd1;
    end
  end

  assign check_tag = (released ? hash_sum : hash_r) & TAG_MASK;

  always_comb begin
    if (held_cnt_nxt != 3'd4)
      dec_status = STATUS_SHORT;
    else if (held_nxt[0] != check_tag[7:0]   || held_nxt[1] != check_tag[15:8] ||
             held_nxt[2] != check_tag[23:16] || held_nxt[3] != check_tag[31:24])
      dec_status = STATUS_MISMATCH;
    else
      dec_status = STATUS_OK;
  end

  // next state and result
  always_comb begin
    hash_nxt     = hash_r;
    pos_nxt      = pos_r;
    tag_cnt_nxt  = tag_cnt_r;
    tag_nxt      = tag_r;
    push         = 1'b0;
    push_data    = '{out_byte: 8'd0, byte_present: 1'b0, end_of_message: 1'b0,
                     status: STATUS_OK};

    if (tag_go) begin
      push                     = 1'b1;
      push_data.out_byte       = tag_r[7:0] ^ key_byte;
      push_data.byte_present   = 1'b1;
      push_data.end_of_message = (tag_cnt_r == 3'd1);
      tag_nxt                  = tag_r >> 8;
      tag_cnt_nxt              = tag_cnt_r - 3'd1;
      pos_nxt                  = (tag_cnt_r == 3'd1) ? '0 : key_pos + KEY_POS_W'(1);
    end else if (item_go) begin
      pos_nxt = key_pos + KEY_POS_W'(1);
      if (cfg.mode == MODE_ENCRYPT) begin
        push                   = 1'b1;
        push_data.out_byte     = plain;
        push_data.byte_present = 1'b1;
        hash_nxt               = hash_sum;
        if (in_fin_r) begin
          tag_nxt     = hash_sum & TAG_MASK;
          tag_cnt_nxt = 3'd4;
          hash_nxt    = HASH_START;
        end
      end else begin
        if (released) hash_nxt = hash_sum;
        push                   = released || in_fin_r;
        push_data.out_byte     = released ? held_r[0] : 8'd0;
        push_data.byte_present = released;
        if (in_fin_r) begin
          push_data.end_of_message = 1'b1;
          push_data.status         = dec_status;
          hash_nxt                 = HASH_START;
          pos_nxt                  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r     <= HASH_START;
      pos_r      <= '0;
      held_cnt_r <= '0;
      tag_cnt_r  <= '0;
    end else begin
      hash_r    <= hash_nxt;
      pos_r     <= pos_nxt;
      tag_cnt_r <= tag_cnt_nxt;
      if (item_go) begin
        if (in_fin_r)
          held_cnt_r <= '0;
        else if (cfg.mode == MODE_DECRYPT)
          held_cnt_r <= held_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    if (item_go && cfg.mode == MODE_DECRYPT) begin
      for (int i = 0; i < 4; i++) held_r[i] <= held_nxt[i];
    end
  end

endmodule : xcht_core

`default_nettype wire

// File: rtl/core/xor_cipher_with_hash_tag.sv
// Repeating-key XOR cipher with DJB2 tag: one byte in, up to five results out.
// Usage:
//   in_ch  - message bytes, final_byte set on the last byte of a message.
//   out_ch - results: out_byte/byte_present, end_of_message and status.
//   cfg_ch - register writes (0 mode, 1 key length, 2..5 key words), always
//            ready; write only while no message results are outstanding.
// Encrypt: each byte gives one ciphertext transfer; the final byte is
//   followed by four tag transfers (DJB2 masked to 31 bits, low byte first,
//   still XORed with the key), the last one marked end_of_message.
// Decrypt: the last four bytes are held as the tag; earlier bytes come out
//   four bytes late. The final byte gives one transfer with end_of_message
//   and status (0 ok, 1 tag mismatch, 2 shorter than four bytes); discard
//   the message unless status is ok.
// Path: a result passes through the input register and then the two-entry
//   result buffer before it is offered on out_ch.
// Throughput: one byte per cycle while the buffer has space; an encrypt final
//   byte holds the input while the tag leaves through the shared key sequencer.
// Reset (rst_n low, synchronous): mode encrypt, key length 1, key zero,
//   hash 5381, key position 0, buffers empty.
// Stall: when out_ch is not ready the buffer fills; once two results wait
//   and the input register holds a byte, in_ch.ready drops; nothing is dropped.
`default_nettype none

module xor_cipher_with_hash_tag (
  input  wire logic   clk,
  input  wire logic   rst_n,
  xcht_in_if.sink     in_ch,
  xcht_out_if.source  out_ch,
  xcht_cfg_if.sink    cfg_ch
);
  import xcht_pkg::*;

  cfg_t    cfg;
  logic    has_space;
  logic    push;
  result_t push_data;

  xcht_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // byte processing and tag sequencing; pushes at most one result a cycle
  xcht_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .has_space (has_space),
    .push      (push),
    .push_data (push_data)
  );

  // decouples out_ch.ready from in_ch.ready
  xcht_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .has_space (has_space),
    .out_ch    (out_ch)
  );

endmodule : xor_cipher_with_hash_tag

`default_nettype wire
